/* rtl/cau_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cau_pkg: shared types and constants of the complex arithmetic unit
// Operand widths, operation and status codes, the records that travel
// down the pipeline, and the saturation helper.
// ----------------------------------------------------------------------------
package cau_pkg;

	localparam int DATA_W    = 32;
	localparam int WIDTH     = 32;
	localparam int FRAC_BITS = 16;
	localparam int PW        = 2 * WIDTH;
	localparam int SW        = PW + 2;
	localparam int AW        = WIDTH + 1;
	localparam int NW        = PW + FRAC_BITS;
	localparam int QB        = WIDTH + 1;

	typedef enum logic [1:0] {
		FN_ADD = 2'd0,
		FN_SUB = 2'd1,
		FN_MUL = 2'd2,
		FN_DIV = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK  = 2'd0,
		ST_SAT = 2'd1,
		ST_DZ  = 2'd2
	} status_t;

	typedef struct packed {
		logic [WIDTH-1:0] val;
		logic             ovf;
	} sat_t;

	typedef struct packed {
		logic             is_div;
		logic             dz;
		logic [WIDTH-1:0] re;
		logic [WIDTH-1:0] im;
		status_t          status;
	} item_t;

	typedef struct packed {
		logic          neg;
		logic          ovf;
		logic [PW-1:0] r;
		logic [QB-1:0] nb;
		logic [QB-1:0] q;
	} lane_t;

	typedef struct packed {
		item_t         item;
		logic [PW-1:0] den;
		lane_t         re;
		lane_t         im;
	} dstage_t;

	function automatic sat_t saturate(input logic signed [SW-1:0] v);
		logic signed [SW-1:0] hi;
		logic signed [SW-1:0] lo;
		sat_t                 r;
		hi = {{(SW-WIDTH+1){1'b0}}, {(WIDTH-1){1'b1}}};
		lo = {{(SW-WIDTH+1){1'b1}}, {(WIDTH-1){1'b0}}};
		if (v > hi) begin
			r.val = hi[WIDTH-1:0];
			r.ovf = 1'b1;
		end else if (v < lo) begin
			r.val = lo[WIDTH-1:0];
			r.ovf = 1'b1;
		end else begin
			r.val = v[WIDTH-1:0];
			r.ovf = 1'b0;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

/* rtl/cau_prep.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cau_prep: front stages of the complex arithmetic unit
// Forms the partial products, combines them, finishes add, subtract and
// multiply, and sets up the long division for divide requests.
// ----------------------------------------------------------------------------
module cau_prep (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    en,
	input  wire logic                    in_vld,
	input  wire logic [1:0]              func,
	input  wire logic [31:0]             a_real,
	input  wire logic [31:0]             a_imag,
	input  wire logic [31:0]             b_real,
	input  wire logic [31:0]             b_imag,
	output logic                         out_vld,
	output cau_pkg::dstage_t             out_stage
);
	import cau_pkg::*;

	logic signed [WIDTH-1:0] ar, ai, br, bi;

	logic                  vld_s1;
	func_t                 func_s1;
	logic signed [PW-1:0]  p_rr_s1, p_ii_s1, p_ir_s1, p_ri_s1, p_bb_s1, p_cc_s1;
	logic signed [AW-1:0]  sre_s1, sim_s1;
	logic                  dz_s1;

	logic                  vld_s2;
	func_t                 func_s2;
	logic signed [SW-1:0]  acc_re_s2, acc_im_s2;
	logic signed [AW-1:0]  sre_s2, sim_s2;
	logic [PW-1:0]         den_s2;
	logic                  dz_s2;

	logic                  vld_s3;
	dstage_t               stage_s3;
	dstage_t               stage_d;

	assign ar = a_real[WIDTH-1:0];
	assign ai = a_imag[WIDTH-1:0];
	assign br = b_real[WIDTH-1:0];
	assign bi = b_imag[WIDTH-1:0];

	function automatic lane_t lane_init(input logic signed [SW-1:0] acc,
			input logic [PW-1:0] den);
		logic [PW-1:0] mag;
		logic [NW-1:0] n;
		lane_t         l;
		mag   = acc < 0 ? PW'(-acc) : PW'(acc);
		n     = NW'(mag) << FRAC_BITS;
		l.neg = acc < 0;
		l.ovf = n[NW-1:QB] >= den;
		l.r   = PW'(n[NW-1:QB]);
		l.nb  = n[QB-1:0];
		l.q   = '0;
		return l;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			func_s1 <= func_t'(func);
			p_rr_s1 <= ar * br;
			p_ii_s1 <= ai * bi;
			p_ir_s1 <= ai * br;
			p_ri_s1 <= ar * bi;
			p_bb_s1 <= br * br;
			p_cc_s1 <= bi * bi;
			if (func_t'(func) == FN_SUB) begin
				sre_s1 <= AW'(ar) - AW'(br);
				sim_s1 <= AW'(ai) - AW'(bi);
			end else begin
				sre_s1 <= AW'(ar) + AW'(br);
				sim_s1 <= AW'(ai) + AW'(bi);
			end
			dz_s1 <= (br == '0) && (bi == '0);

			func_s2 <= func_s1;
			sre_s2  <= sre_s1;
			sim_s2  <= sim_s1;
			dz_s2   <= dz_s1;
			den_s2  <= PW'(p_bb_s1) + PW'(p_cc_s1);
			if (func_s1 == FN_DIV) begin
				acc_re_s2 <= SW'(p_rr_s1) + SW'(p_ii_s1);
				acc_im_s2 <= SW'(p_ir_s1) - SW'(p_ri_s1);
			end else begin
				acc_re_s2 <= SW'(p_rr_s1) - SW'(p_ii_s1);
				acc_im_s2 <= SW'(p_ir_s1) + SW'(p_ri_s1);
			end

			stage_s3 <= stage_d;
		end
	end

	always_comb begin
		logic signed [SW-1:0] vre;
		logic signed [SW-1:0] vim;
		sat_t                 sre;
		sat_t                 sim;
		if (func_s2 == FN_MUL) begin
			vre = acc_re_s2 >>> FRAC_BITS;
			vim = acc_im_s2 >>> FRAC_BITS;
		end else begin
			vre = SW'(sre_s2);
			vim = SW'(sim_s2);
		end
		sre = saturate(vre);
		sim = saturate(vim);
		stage_d.item.is_div = func_s2 == FN_DIV;
		stage_d.item.dz     = dz_s2;
		stage_d.item.re     = sre.val;
		stage_d.item.im     = sim.val;
		stage_d.item.status = (sre.ovf || sim.ovf) ? ST_SAT : ST_OK;
		stage_d.den         = den_s2;
		stage_d.re          = lane_init(acc_re_s2, den_s2);
		stage_d.im          = lane_init(acc_im_s2, den_s2);
	end

	assign out_vld   = vld_s3;
	assign out_stage = stage_s3;

endmodule
`default_nettype wire

/* rtl/cau_div_step.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cau_div_step: one stage of the quotient pipeline
// Develops one quotient bit of both division lanes by compare and subtract.
// ----------------------------------------------------------------------------
module cau_div_step (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic             in_vld,
	input  cau_pkg::dstage_t      in_stage,
	output logic                  out_vld,
	output cau_pkg::dstage_t      out_stage
);
	import cau_pkg::*;

	logic    vld_q;
	dstage_t stage_q;
	dstage_t stage_d;

	function automatic lane_t step(input lane_t l, input logic [PW-1:0] d);
		logic [PW:0] t;
		logic        qb;
		lane_t       o;
		t  = {l.r, l.nb[QB-1]};
		qb = t >= {1'b0, d};
		if (qb) begin
			t = t - {1'b0, d};
		end
		o     = l;
		o.r   = t[PW-1:0];
		o.nb  = l.nb << 1;
		o.q   = {l.q[QB-2:0], qb};
		return o;
	endfunction

	always_comb begin
		stage_d    = in_stage;
		stage_d.re = step(in_stage.re, in_stage.den);
		stage_d.im = step(in_stage.im, in_stage.den);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			stage_q <= stage_d;
		end
	end

	assign out_vld   = vld_q;
	assign out_stage = stage_q;

endmodule
`default_nettype wire

/* rtl/cau_divider.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cau_divider: quotient pipeline of the complex arithmetic unit
// A chain of step stages, one per quotient bit, shared by every request.
// ----------------------------------------------------------------------------
module cau_divider (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic             in_vld,
	input  cau_pkg::dstage_t      in_stage,
	output logic                  out_vld,
	output cau_pkg::dstage_t      out_stage
);
	import cau_pkg::*;

	logic    vld_chain [QB+1];
	dstage_t stage_chain [QB+1];

	assign vld_chain[0]   = in_vld;
	assign stage_chain[0] = in_stage;

	for (genvar i = 0; i < QB; i++) begin : g_step
		cau_div_step u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_vld    (vld_chain[i]),
			.in_stage  (stage_chain[i]),
			.out_vld   (vld_chain[i+1]),
			.out_stage (stage_chain[i+1])
		);
	end

	assign out_vld   = vld_chain[QB];
	assign out_stage = stage_chain[QB];

endmodule
`default_nettype wire

/* rtl/complex_arith_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// complex_arith_unit: pipelined complex add, subtract, multiply and divide
// Every request passes through 37 register stages: three for the products
// and their sums, 33 for the quotient bits of the division, one output
// register. A new request is taken each cycle; a result held in the output
// register while out_ready is low freezes the whole pipeline. Operands and
// results are signed Q16.16; out-of-range parts saturate, and division by
// zero returns zeros with its own status.
// ----------------------------------------------------------------------------
module complex_arith_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  func,
	input  wire logic [31:0] a_real,
	input  wire logic [31:0] a_imag,
	input  wire logic [31:0] b_real,
	input  wire logic [31:0] b_imag,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      res_real,
	output logic [31:0]      res_imag,
	output logic [1:0]       status
);
	import cau_pkg::*;

	logic             en;
	logic             prep_vld, div_vld;
	dstage_t          prep_stage, div_stage;
	logic             out_vld_q;
	logic [WIDTH-1:0] re_q, im_q, re_d, im_d;
	status_t          status_q, status_d;

	function automatic sat_t finish(input lane_t l);
		logic [QB-1:0] lim_p;
		logic [QB-1:0] lim_n;
		logic [QB-1:0] v;
		sat_t          r;
		lim_p = {2'b00, {(WIDTH-1){1'b1}}};
		lim_n = {2'b01, {(WIDTH-1){1'b0}}};
		v     = l.neg ? -l.q : l.q;
		if (l.ovf || (l.neg ? (l.q > lim_n) : (l.q > lim_p))) begin
			r.val = l.neg ? lim_n[WIDTH-1:0] : lim_p[WIDTH-1:0];
			r.ovf = 1'b1;
		end else begin
			r.val = v[WIDTH-1:0];
			r.ovf = 1'b0;
		end
		return r;
	endfunction

	assign en       = !out_vld_q || out_ready;
	assign in_ready = en;

	cau_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_vld    (in_valid),
		.func      (func),
		.a_real    (a_real),
		.a_imag    (a_imag),
		.b_real    (b_real),
		.b_imag    (b_imag),
		.out_vld   (prep_vld),
		.out_stage (prep_stage)
	);

	cau_divider u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_vld    (prep_vld),
		.in_stage  (prep_stage),
		.out_vld   (div_vld),
		.out_stage (div_stage)
	);

	always_comb begin
		sat_t fre;
		sat_t fim;
		fre = finish(div_stage.re);
		fim = finish(div_stage.im);
		if (!div_stage.item.is_div) begin
			re_d     = div_stage.item.re;
			im_d     = div_stage.item.im;
			status_d = div_stage.item.status;
		end else if (div_stage.item.dz) begin
			re_d     = '0;
			im_d     = '0;
			status_d = ST_DZ;
		end else begin
			re_d     = fre.val;
			im_d     = fim.val;
			status_d = (fre.ovf || fim.ovf) ? ST_SAT : ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= div_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			re_q     <= re_d;
			im_q     <= im_d;
			status_q <= status_d;
		end
	end

	assign out_valid = out_vld_q;
	assign res_real  = DATA_W'(signed'(re_q));
	assign res_imag  = DATA_W'(signed'(im_q));
	assign status    = status_q;

endmodule
`default_nettype wire

/* test/complex_arith_checker.sv */
// ----------------------------------------------------------------------------
// complex_arith_checker: result predictor and scoreboard
// Watches the request and result channels of the complex arithmetic unit, computes the
// expected result of every accepted request with exact wide arithmetic, and
// compares each returned result field by field in order of arrival.
// ----------------------------------------------------------------------------
module complex_arith_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic [1:0]  func,
	input  wire logic [31:0] a_real,
	input  wire logic [31:0] a_imag,
	input  wire logic [31:0] b_real,
	input  wire logic [31:0] b_imag,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic [31:0] res_real,
	input  wire logic [31:0] res_imag,
	input  wire logic [1:0]  status,
	output int               errors,
	output int               pending,
	output int               checked
);
	import cau_pkg::*;

	typedef struct {
		logic [31:0] re;
		logic [31:0] im;
		status_t     st;
	} cplx_result_t;

	cplx_result_t expected_q[$];

	function automatic logic [31:0] clamp32(input logic signed [127:0] v, inout logic ovf);
		logic signed [127:0] hi;
		logic signed [127:0] lo;
		hi = 128'sh7fffffff;
		lo = -128'sh80000000;
		if (v > hi) begin
			ovf = 1'b1;
			return 32'h7fffffff;
		end else if (v < lo) begin
			ovf = 1'b1;
			return 32'h80000000;
		end
		return v[31:0];
	endfunction

	function automatic cplx_result_t compute_result(input func_t f, input logic [31:0] ar,
		input logic [31:0] ai, input logic [31:0] br, input logic [31:0] bi);
		logic signed [127:0] sar, sai, sbr, sbi, vre, vim, den, mag, q;
		logic                ovf;
		cplx_result_t        r;
		sar = $signed(ar);
		sai = $signed(ai);
		sbr = $signed(br);
		sbi = $signed(bi);
		ovf = 1'b0;
		case (f)
			FN_ADD: begin
				vre = sar + sbr;
				vim = sai + sbi;
			end
			FN_SUB: begin
				vre = sar - sbr;
				vim = sai - sbi;
			end
			FN_MUL: begin
				vre = (sar * sbr - sai * sbi) >>> FRAC_BITS;
				vim = (sai * sbr + sar * sbi) >>> FRAC_BITS;
			end
			default: begin
				den = sbr * sbr + sbi * sbi;
				if (den == 0) begin
					r.re = '0;
					r.im = '0;
					r.st = ST_DZ;
					return r;
				end
				vre = sar * sbr + sai * sbi;
				mag = vre < 0 ? -vre : vre;
				q = (mag <<< FRAC_BITS) / den;
				vre = vre < 0 ? -q : q;
				vim = sai * sbr - sar * sbi;
				mag = vim < 0 ? -vim : vim;
				q = (mag <<< FRAC_BITS) / den;
				vim = vim < 0 ? -q : q;
			end
		endcase
		r.re = clamp32(vre, ovf);
		r.im = clamp32(vim, ovf);
		r.st = ovf ? ST_SAT : ST_OK;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("mismatch on result %0d: %s got %h expected %h", checked, what, got, want);
		errors++;
	endtask

	initial begin
		errors  = 0;
		pending = 0;
		checked = 0;
	end

	always @(posedge clk) begin
		cplx_result_t e;
		if (arst_n && in_valid && in_ready)
			expected_q.push_back(compute_result(func_t'(func), a_real, a_imag, b_real, b_imag));
		if (arst_n && out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				report_mismatch("unexpected result", res_real, 32'h0);
			end else begin
				e = expected_q.pop_front();
				if (res_real !== e.re)
					report_mismatch("res_real", res_real, e.re);
				if (res_imag !== e.im)
					report_mismatch("res_imag", res_imag, e.im);
				if (status !== e.st)
					report_mismatch("status", {30'd0, status}, {30'd0, e.st});
			end
			checked++;
		end
		pending = expected_q.size();
	end

endmodule

/* test/tb_complex_arith_unit.sv */
// ----------------------------------------------------------------------------
// tb_complex_arith_unit: testbench of the complex arithmetic unit
// Sends directed corner requests for every operation, then a long random mix
// of full-range, small and extreme operands, with random gaps on both sides
// and one long receiver hold-off that backs up the pipeline.
// ----------------------------------------------------------------------------
module tb_complex_arith_unit;
	import cau_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int RANDOM_COUNT   = 1350;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  func;
	logic [31:0] a_real, a_imag, b_real, b_imag;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] res_real, res_imag;
	logic [1:0]  status;
	int          errors, pending, checked;
	int          sent;
	logic        hold_request;
	int          idle_cycles;

	complex_arith_unit DUT (.*);

	complex_arith_checker u_checker (.*);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic no_idle();
		return sent >= 300 && sent < 500;
	endfunction

	task automatic send_request(input func_t f, input logic [31:0] ar, input logic [31:0] ai,
		input logic [31:0] br, input logic [31:0] bi);
		while (!no_idle() && $urandom_range(99) < 17) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		func     = f;
		a_real   = ar;
		a_imag   = ai;
		b_real   = br;
		b_imag   = bi;
		do
			@(posedge clk);
		while (!in_ready);
		sent++;
		@(negedge clk);
	endtask

	function automatic logic [31:0] random_operand();
		logic [31:0] x;
		x = $urandom;
		case ($urandom_range(3))
			0: return x;
			1: return {{12{x[19]}}, x[19:0]};
			2: return {{8{x[23]}}, x[23:0]};
			default: begin
				case ($urandom_range(4))
					0: return 32'h0;
					1: return 32'h1;
					2: return 32'hffffffff;
					3: return 32'h7fffffff;
					default: return 32'h80000000;
				endcase
			end
		endcase
	endfunction

	initial begin
		logic [31:0] br, bi;
		func_t       f;
		in_valid     = 1'b0;
		func         = FN_ADD;
		a_real       = '0;
		a_imag       = '0;
		b_real       = '0;
		b_imag       = '0;
		sent         = 0;
		hold_request = 1'b0;
		arst_n       = 1'b0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_request(FN_ADD, 32'h00010000, 32'h00020000, 32'h00030000, 32'hffff0000);
		send_request(FN_ADD, 32'h7fffffff, 32'h80000000, 32'h00000001, 32'hffffffff);
		send_request(FN_ADD, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
		send_request(FN_SUB, 32'h00050000, 32'h00000000, 32'h00020000, 32'h00010000);
		send_request(FN_SUB, 32'h80000000, 32'h7fffffff, 32'h00000001, 32'hffffffff);
		send_request(FN_SUB, 32'h00000000, 32'h00000000, 32'h80000000, 32'h80000000);
		send_request(FN_MUL, 32'h00010000, 32'h00010000, 32'h00010000, 32'hffff0000);
		send_request(FN_MUL, 32'hffffffff, 32'h00000000, 32'h00000001, 32'h00000000);
		send_request(FN_MUL, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
		send_request(FN_MUL, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
		send_request(FN_MUL, 32'h00008000, 32'hffff8000, 32'h00008000, 32'h00008000);
		send_request(FN_DIV, 32'h00010000, 32'h00020000, 32'h00000000, 32'h00000000);
		send_request(FN_DIV, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000);
		send_request(FN_DIV, 32'h00030000, 32'h00040000, 32'h00010000, 32'h00020000);
		send_request(FN_DIV, 32'h7fffffff, 32'h80000000, 32'h00000001, 32'h00000000);
		send_request(FN_DIV, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
		send_request(FN_DIV, 32'hfffeffff, 32'h00000001, 32'h00030000, 32'h00000000);
		send_request(FN_DIV, 32'h00000001, 32'hffffffff, 32'h7fffffff, 32'h7fffffff);
		send_request(FN_DIV, 32'h00010000, 32'h00000000, 32'h00000000, 32'hffffffff);

		for (int i = 0; i < RANDOM_COUNT; i++) begin
			if (i == 700)
				hold_request = 1'b1;
			f  = func_t'($urandom_range(3));
			br = random_operand();
			bi = random_operand();
			if (f == FN_DIV && $urandom_range(19) == 0) begin
				br = '0;
				bi = '0;
			end
			send_request(f, random_operand(), random_operand(), br, bi);
		end
		in_valid = 1'b0;

		while (pending != 0)
			@(negedge clk);
		repeat (60) @(negedge clk);
		$display("checked %0d results from %0d requests across all four operations,",
			checked, sent);
		$display("with divide-by-zero, saturation and a long output back-pressure stretch");
		if (errors == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				out_ready    = 1'b0;
				repeat (200) @(negedge clk);
			end
			out_ready = no_idle() || $urandom_range(99) >= 17;
		end
	end

	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog expired with %0d results outstanding", pending);
				$display("simulation failed");
				$finish;
			end
		end
	end

endmodule
